/* hw/rtl/olp_pkg.sv */
`default_nettype none

package olp_pkg;

  // default configuration
  localparam int MAX_STREAMS_DEF = 8;
  localparam int LENGTH_BITS_DEF = 24;

  // fixed field widths of a result item
  localparam int KIND_W  = 2;
  localparam int INDEX_W = 3;
  localparam int VALUE_W = 24;
  localparam int ERR_W   = 2;

  // page header layout
  localparam logic [4:0] HDR_VERSION   = 5'd4;
  localparam logic [4:0] HDR_TYPE      = 5'd5;
  localparam logic [4:0] HDR_SERIAL_LO = 5'd14;
  localparam logic [4:0] HDR_SERIAL_HI = 5'd17;
  localparam logic [4:0] HDR_SEGMENTS  = 5'd26;
  localparam logic [7:0] LACING_MAX    = 8'd255;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_LEN  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BYTE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_ERR  = 2'd2;

  // error codes
  localparam logic [ERR_W-1:0] ERR_CAPTURE = 2'd0;
  localparam logic [ERR_W-1:0] ERR_VERSION = 2'd1;
  localparam logic [ERR_W-1:0] ERR_FULL    = 2'd2;

  // one result item
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] stream_index;
    logic [VALUE_W-1:0] value;
    logic [ERR_W-1:0]   error_code;
    logic               page_end;
  } result_t;

  // capture pattern "OggS", one byte per header position
  function automatic logic [7:0] capture_byte(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0: c = 8'h4F;
      2'd1: c = 8'h67;
      2'd2: c = 8'h67;
      default: c = 8'h53;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/ogg_page_lacing_parser.sv */
`default_nettype none

// Ogg page parser: takes one bitstream byte per item and returns at most one
// result per byte (packet length, tagged payload byte or page error). It
// accepts one byte every clock cycle; the only stall is when two results are
// waiting in the two-entry output buffer. The running packet length of each
// stream lives in a small pending-length RAM: it is read on the last header
// byte of a page (registered read, used by the first lacing byte), kept in
// an accumulator through the lacing table and written back on the last
// lacing byte. Stream serials sit in a register table that is compared in
// parallel, with the result registered ahead of the mapping byte. No memory
// clearing pass is needed after reset.
module ogg_page_lacing_parser #(
  parameter int MAX_STREAMS = olp_pkg::MAX_STREAMS_DEF,
  parameter int LENGTH_BITS = olp_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [7:0]                   data_byte,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic [olp_pkg::KIND_W-1:0]        kind,
  output logic [olp_pkg::INDEX_W-1:0]       stream_index,
  output logic [olp_pkg::VALUE_W-1:0]       value,
  output logic [olp_pkg::ERR_W-1:0]         error_code,
  output logic                              page_end
);

  localparam int SLOT_W = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
  localparam int CNT_W  = $clog2(MAX_STREAMS + 1);
  localparam logic [CNT_W-1:0]       COUNT_FULL = CNT_W'(MAX_STREAMS);
  localparam logic [LENGTH_BITS-1:0] LEN_MAX    = {LENGTH_BITS{1'b1}};

  typedef enum logic [2:0] {
    PH_HEADER  = 3'b001,
    PH_LACING  = 3'b010,
    PH_PAYLOAD = 3'b100
  } phase_t;

  phase_t                 phase, phase_next;
  logic [4:0]             hdr_count, hdr_count_next, hdr_eff;
  logic                   cont_flag, cont_flag_next;
  logic [31:0]            serial_shift, serial_shift_next;
  logic [7:0]             segs_left, segs_left_next;
  logic [15:0]            pay_left, pay_left_next;
  logic [SLOT_W-1:0]      cur_stream, cur_stream_next;
  logic [CNT_W-1:0]       stream_count;
  logic [MAX_STREAMS-1:0] entry_valid;
  logic [31:0]            serials [MAX_STREAMS];
  logic [MAX_STREAMS-1:0] hit;
  logic [LENGTH_BITS-1:0] acc, acc_next;
  logic                   load, load_next;
  logic                   fresh, fresh_next;

  logic                   in_fire;
  logic                   res_valid;
  olp_pkg::result_t       res, out_data;
  logic                   buf_space;

  logic                   alloc;
  logic [SLOT_W-1:0]      alloc_slot, hit_slot, map_slot;
  logic                   ram_we, ram_re;
  logic [SLOT_W-1:0]      ram_waddr, ram_raddr;
  logic [LENGTH_BITS-1:0] ram_wdata, ram_rdata;
  logic [LENGTH_BITS-1:0] len_base, len_sat;
  logic [LENGTH_BITS:0]   len_sum;
  logic                   need_alloc;

  assign in_ready   = buf_space;
  assign in_fire    = in_valid && in_ready;
  assign alloc_slot = SLOT_W'(stream_count);
  assign hdr_eff    = (hdr_count > olp_pkg::HDR_SEGMENTS) ? 5'd0 : hdr_count;

  // first matching table entry
  always_comb begin
    hit_slot = '0;
    for (int i = MAX_STREAMS - 1; i >= 0; i--) begin
      if (hit[i]) begin
        hit_slot = SLOT_W'(i);
      end
    end
  end

  // pending length update for a lacing byte
  always_comb begin
    if (load) begin
      len_base = fresh ? '0 : ram_rdata;
    end else begin
      len_base = acc;
    end
    len_sum = {1'b0, len_base} + (LENGTH_BITS + 1)'(data_byte);
    len_sat = len_sum[LENGTH_BITS] ? LEN_MAX : len_sum[LENGTH_BITS-1:0];
  end

  // per-byte parser step
  always_comb begin
    phase_next        = phase;
    hdr_count_next    = hdr_count;
    cont_flag_next    = cont_flag;
    serial_shift_next = serial_shift;
    segs_left_next    = segs_left;
    pay_left_next     = pay_left;
    cur_stream_next   = cur_stream;
    acc_next          = acc;
    load_next         = load;
    fresh_next        = fresh;
    alloc             = 1'b0;
    ram_we            = 1'b0;
    ram_re            = 1'b0;
    ram_waddr         = cur_stream;
    ram_raddr         = cur_stream;
    ram_wdata         = '0;
    res_valid         = 1'b0;
    res               = '0;
    need_alloc        = !(|hit);
    map_slot          = need_alloc ? alloc_slot : hit_slot;

    if (in_fire) begin
      case (phase)
        PH_LACING: begin
          pay_left_next  = pay_left + {8'd0, data_byte};
          load_next      = 1'b0;
          acc_next       = len_sat;
          if (data_byte != olp_pkg::LACING_MAX) begin
            res_valid          = 1'b1;
            res.kind           = olp_pkg::KIND_LEN;
            res.stream_index   = olp_pkg::INDEX_W'(cur_stream);
            res.value          = olp_pkg::VALUE_W'(len_sat);
            acc_next           = '0;
          end
          segs_left_next = segs_left - 8'd1;
          if (segs_left_next == 8'd0) begin
            ram_we         = 1'b1;
            ram_wdata      = acc_next;
            hdr_count_next = '0;
            phase_next     = (pay_left_next != 16'd0) ? PH_PAYLOAD : PH_HEADER;
          end
        end
        PH_PAYLOAD: begin
          pay_left_next    = pay_left - 16'd1;
          res_valid        = 1'b1;
          res.kind         = olp_pkg::KIND_BYTE;
          res.stream_index = olp_pkg::INDEX_W'(cur_stream);
          res.value        = olp_pkg::VALUE_W'(data_byte);
          res.page_end     = (pay_left_next == 16'd0);
          if (pay_left_next == 16'd0) begin
            phase_next     = PH_HEADER;
            hdr_count_next = '0;
          end
        end
        default: begin
          // header bytes
          phase_next     = PH_HEADER;
          hdr_count_next = hdr_eff + 5'd1;
          if (hdr_eff < olp_pkg::HDR_VERSION) begin
            if (data_byte != olp_pkg::capture_byte(hdr_eff[1:0])) begin
              res_valid      = 1'b1;
              res.kind       = olp_pkg::KIND_ERR;
              res.error_code = olp_pkg::ERR_CAPTURE;
              hdr_count_next = '0;
            end
          end else if (hdr_eff == olp_pkg::HDR_VERSION) begin
            if (data_byte != 8'd0) begin
              res_valid      = 1'b1;
              res.kind       = olp_pkg::KIND_ERR;
              res.error_code = olp_pkg::ERR_VERSION;
              hdr_count_next = '0;
            end
          end else if (hdr_eff == olp_pkg::HDR_TYPE) begin
            cont_flag_next = data_byte[0];
          end else if (hdr_eff >= olp_pkg::HDR_SERIAL_LO &&
                       hdr_eff <= olp_pkg::HDR_SERIAL_HI) begin
            serial_shift_next = {data_byte, serial_shift[31:8]};
          end else if (hdr_eff == olp_pkg::HDR_SEGMENTS) begin
            hdr_count_next = '0;
            if (need_alloc && stream_count == COUNT_FULL) begin
              res_valid      = 1'b1;
              res.kind       = olp_pkg::KIND_ERR;
              res.error_code = olp_pkg::ERR_FULL;
            end else begin
              alloc           = need_alloc;
              cur_stream_next = map_slot;
              segs_left_next  = data_byte;
              pay_left_next   = '0;
              if (data_byte != 8'd0) begin
                // fetch the stream's pending length for the first lacing byte
                phase_next = PH_LACING;
                load_next  = 1'b1;
                fresh_next = need_alloc || !cont_flag;
                ram_re     = 1'b1;
                ram_raddr  = map_slot;
              end else if (need_alloc || !cont_flag) begin
                // empty page that starts a fresh packet
                ram_we    = 1'b1;
                ram_waddr = map_slot;
              end
            end
          end
        end
      endcase
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_HEADER;
      hdr_count    <= '0;
      cont_flag    <= 1'b0;
      serial_shift <= '0;
      segs_left    <= '0;
      pay_left     <= '0;
      cur_stream   <= '0;
      stream_count <= '0;
      entry_valid  <= '0;
      load         <= 1'b0;
    end else begin
      phase        <= phase_next;
      hdr_count    <= hdr_count_next;
      cont_flag    <= cont_flag_next;
      serial_shift <= serial_shift_next;
      segs_left    <= segs_left_next;
      pay_left     <= pay_left_next;
      cur_stream   <= cur_stream_next;
      load         <= load_next;
      if (alloc) begin
        stream_count            <= stream_count + CNT_W'(1);
        entry_valid[alloc_slot] <= 1'b1;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    acc   <= acc_next;
    fresh <= fresh_next;
    if (alloc) begin
      serials[alloc_slot] <= serial_shift;
    end
  end

  // serial table compare, registered ahead of the mapping byte
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_STREAMS; i++) begin
      hit[i] <= entry_valid[i] && (serials[i] == serial_shift);
    end
  end

  olp_ram #(
    .WIDTH(LENGTH_BITS),
    .DEPTH(MAX_STREAMS)
  ) u_pending (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (ram_re),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  olp_skid u_out (
    .clk      (clk),
    .rst      (rst),
    .push     (res_valid),
    .push_data(res),
    .space    (buf_space),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  assign kind         = out_data.kind;
  assign stream_index = out_data.stream_index;
  assign value        = out_data.value;
  assign error_code   = out_data.error_code;
  assign page_end     = out_data.page_end;

  // checks
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    stream_count <= COUNT_FULL)
    else $error("stream count beyond table size");

  a_valid_count: assert property (@(posedge clk) disable iff (rst)
    $countones(entry_valid) == int'(stream_count))
    else $error("table valid bits disagree with stream count");

  a_lacing_segs: assert property (@(posedge clk) disable iff (rst)
    phase == PH_LACING |-> segs_left != 8'd0)
    else $error("lacing phase with no segments left");

  a_load_phase: assert property (@(posedge clk) disable iff (rst)
    load |-> phase == PH_LACING)
    else $error("pending length fetch outside lacing phase");

  a_err_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && kind == olp_pkg::KIND_ERR |->
      value == '0 && stream_index == '0 && page_end == 1'b0)
    else $error("error item carries stray fields");

endmodule

`default_nettype wire

/* hw/rtl/olp_ram.sv */
`default_nettype none

module olp_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 8
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                       wdata,
  input  wire logic                                   re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/olp_skid.sv */
`default_nettype none

module olp_skid (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire olp_pkg::result_t push_data,
  output logic                  space,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output olp_pkg::result_t      out_data
);

  logic             skid_valid;
  olp_pkg::result_t skid_data;
  logic             pop;

  assign pop   = out_valid && out_ready;
  assign space = !skid_valid;

  // control: output register plus one skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (push) begin
        if (out_valid && !pop) begin
          skid_valid <= 1'b1;
        end else begin
          out_valid <= 1'b1;
        end
      end else if (pop) begin
        if (skid_valid) begin
          skid_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (push) begin
      if (out_valid && !pop) begin
        skid_data <= push_data;
      end else begin
        out_data <= push_data;
      end
    end else if (pop && skid_valid) begin
      out_data <= skid_data;
    end
  end

endmodule

`default_nettype wire

/* verif/ogg_page_lacing_parser_checker.sv */
`timescale 1ns / 100ps

module ogg_page_lacing_parser_checker (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire logic                        in_ready,
  input  wire logic [7:0]                  data_byte,
  input  wire logic                        out_valid,
  input  wire logic                        out_ready,
  input  wire logic [olp_pkg::KIND_W-1:0]  kind,
  input  wire logic [olp_pkg::INDEX_W-1:0] stream_index,
  input  wire logic [olp_pkg::VALUE_W-1:0] value,
  input  wire logic [olp_pkg::ERR_W-1:0]   error_code,
  input  wire logic                        page_end,
  output int                               fail_count,
  output int                               results_due
);

  import olp_pkg::*;

  localparam int MAX_STREAMS = MAX_STREAMS_DEF;
  localparam int LENGTH_BITS = LENGTH_BITS_DEF;
  localparam logic [31:0] OGG_CAPTURE = "OggS";
  localparam int REPORT_MAX = 10;

  typedef enum logic [1:0] {PH_HEADER, PH_LACING, PH_PAYLOAD} parse_phase_e;

  // parser state as seen from the byte stream
  parse_phase_e           parse_ph;
  logic [4:0]             hdr_pos;
  logic                   cont_flag;
  logic [31:0]            serial_acc;
  logic [7:0]             segs_left;
  logic [15:0]            body_left;
  int                     cur_slot;
  int                     slot_count;
  logic [31:0]            slot_serial [MAX_STREAMS];
  logic [LENGTH_BITS-1:0] slot_len [MAX_STREAMS];

  // results still owed by the block, oldest first
  result_t page_results [$];

  // header failure: report and resync on the next byte
  task automatic push_page_error(input logic [ERR_W-1:0] code);
    result_t r;
    r = '0;
    r.kind = KIND_ERR;
    r.error_code = code;
    page_results.push_back(r);
    parse_ph = PH_HEADER;
    hdr_pos = '0;
  endtask

  // advance the parser by one stream byte and queue what it produces
  task automatic parse_byte(input logic [7:0] b);
    result_t r;
    logic [LENGTH_BITS:0] sum;
    int slot;
    r = '0;
    case (parse_ph)
      PH_LACING: begin
        sum = {1'b0, slot_len[cur_slot]} + b;
        if (sum[LENGTH_BITS]) sum = {1'b0, {LENGTH_BITS{1'b1}}};
        slot_len[cur_slot] = sum[LENGTH_BITS-1:0];
        body_left = body_left + b;
        // a lacing value below the maximum closes the packet
        if (b != LACING_MAX) begin
          r.kind = KIND_LEN;
          r.stream_index = cur_slot[INDEX_W-1:0];
          r.value = sum[VALUE_W-1:0];
          page_results.push_back(r);
          slot_len[cur_slot] = '0;
        end
        segs_left = segs_left - 1'b1;
        if (segs_left == 8'd0) begin
          parse_ph = (body_left != 16'd0) ? PH_PAYLOAD : PH_HEADER;
          hdr_pos = '0;
        end
      end
      PH_PAYLOAD: begin
        body_left = body_left - 1'b1;
        r.kind = KIND_BYTE;
        r.stream_index = cur_slot[INDEX_W-1:0];
        r.value = VALUE_W'(b);
        r.page_end = (body_left == 16'd0);
        page_results.push_back(r);
        if (body_left == 16'd0) begin
          parse_ph = PH_HEADER;
          hdr_pos = '0;
        end
      end
      default: begin
        parse_ph = PH_HEADER;
        if (hdr_pos > HDR_SEGMENTS) hdr_pos = '0;
        if (hdr_pos < HDR_VERSION) begin
          if (b != OGG_CAPTURE[(3 - hdr_pos[1:0]) * 8 +: 8]) begin
            push_page_error(ERR_CAPTURE);
            return;
          end
        end else if (hdr_pos == HDR_VERSION) begin
          if (b != 8'h00) begin
            push_page_error(ERR_VERSION);
            return;
          end
        end else if (hdr_pos == HDR_TYPE) begin
          cont_flag = b[0];
        end else if (hdr_pos >= HDR_SERIAL_LO && hdr_pos <= HDR_SERIAL_HI) begin
          serial_acc = {b, serial_acc[31:8]};
        end else if (hdr_pos == HDR_SEGMENTS) begin
          // map the serial to a slot, allocating one when unseen
          slot = -1;
          for (int i = 0; i < slot_count; i++)
            if (slot < 0 && slot_serial[i] == serial_acc) slot = i;
          if (slot < 0) begin
            if (slot_count >= MAX_STREAMS) begin
              push_page_error(ERR_FULL);
              return;
            end
            slot = slot_count;
            slot_serial[slot] = serial_acc;
            slot_len[slot] = '0;
            slot_count++;
          end
          cur_slot = slot;
          if (!cont_flag) slot_len[slot] = '0;
          segs_left = b;
          body_left = '0;
          hdr_pos = '0;
          parse_ph = (b != 8'd0) ? PH_LACING : PH_HEADER;
          return;
        end
        hdr_pos = hdr_pos + 1'b1;
      end
    endcase
  endtask

  task automatic report_mismatch(input string why, input result_t want, input result_t got);
    fail_count++;
    if (fail_count <= REPORT_MAX)
      $display("%0t: %s: expected kind=%0d stream=%0d value=%h err=%0d end=%b,",
               $realtime, why, want.kind, want.stream_index, want.value,
               want.error_code, want.page_end,
               " got kind=%0d stream=%0d value=%h err=%0d end=%b",
               got.kind, got.stream_index, got.value, got.error_code, got.page_end);
  endtask

  // follow accepted bytes, then check each accepted result
  always @(posedge clk) begin : watch
    result_t got;
    result_t want;
    if (rst) begin
      parse_ph = PH_HEADER;
      hdr_pos = '0;
      cont_flag = 1'b0;
      serial_acc = '0;
      segs_left = '0;
      body_left = '0;
      cur_slot = 0;
      slot_count = 0;
      page_results.delete();
    end else begin
      if (in_valid && in_ready) parse_byte(data_byte);
      if (out_valid && out_ready) begin
        got.kind = kind;
        got.stream_index = stream_index;
        got.value = value;
        got.error_code = error_code;
        got.page_end = page_end;
        if (page_results.size() == 0) begin
          report_mismatch("result with none due", '0, got);
        end else begin
          want = page_results.pop_front();
          if (got.kind !== want.kind || got.stream_index !== want.stream_index ||
              got.value !== want.value || got.error_code !== want.error_code ||
              got.page_end !== want.page_end)
            report_mismatch("wrong result", want, got);
        end
      end
    end
    results_due <= page_results.size();
  end

endmodule

/* verif/ogg_page_lacing_parser_tb.sv */
`timescale 1ns / 100ps

module ogg_page_lacing_parser_tb;

  import olp_pkg::*;

  localparam int TOTAL_ITEMS = 1700;
  localparam int STALL_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 16;
  localparam int HOLD_AT = 1500;
  localparam int HOLD_CYCLES = 400;
  localparam logic [31:0] OGG_CAPTURE = "OggS";

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          data_byte = 8'h00;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [KIND_W-1:0]   kind;
  logic [INDEX_W-1:0]  stream_index;
  logic [VALUE_W-1:0]  value;
  logic [ERR_W-1:0]    error_code;
  logic                page_end;
  int                  fail_count;
  int                  results_due;

  int                  sent_bytes = 0;
  int                  idle_cycles = 0;
  bit                  tx_steady = 1'b0;
  logic [31:0]         stream_ids [8];
  logic [7:0]          lacing_tab [$];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  ogg_page_lacing_parser u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .stream_index (stream_index),
    .value        (value),
    .error_code   (error_code),
    .page_end     (page_end)
  );

  ogg_page_lacing_parser_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .kind         (kind),
    .stream_index (stream_index),
    .value        (value),
    .error_code   (error_code),
    .page_end     (page_end),
    .fail_count   (fail_count),
    .results_due  (results_due)
  );

  // idle length: mostly none or short, now and then long
  function automatic int pick_gap(input bit steady);
    int r;
    if (steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // serial that no known stream uses
  function automatic logic [31:0] unseen_serial();
    logic [31:0] s;
    bit clash;
    do begin
      s = $urandom;
      clash = 1'b0;
      foreach (stream_ids[i])
        if (stream_ids[i] == s) clash = 1'b1;
    end while (clash);
    return s;
  endfunction

  // offer one byte after a random gap and wait for the item to be taken
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = pick_gap(tx_steady);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent_bytes++;
  endtask

  // 27-byte page header; bad_pos >= 0 corrupts that byte and stops there
  task automatic send_header(input logic [31:0] serial, input bit cont, input logic [7:0] nseg,
                             input int bad_pos);
    logic [7:0] good;
    logic [7:0] b;
    for (int p = 0; p <= HDR_SEGMENTS; p++) begin
      if (p < HDR_VERSION) good = OGG_CAPTURE[(3 - p) * 8 +: 8];
      else if (p == HDR_VERSION) good = 8'h00;
      else if (p == HDR_TYPE) good = {7'($urandom), cont};
      else if (p >= HDR_SERIAL_LO && p <= HDR_SERIAL_HI)
        good = serial[(p - HDR_SERIAL_LO) * 8 +: 8];
      else if (p == HDR_SEGMENTS) good = nseg;
      else good = 8'($urandom);
      if (p == bad_pos) begin
        do b = 8'($urandom); while (b == good);
        send_byte(b);
        return;
      end
      send_byte(good);
    end
  endtask

  // full page: header, lacing_tab, then random payload of the laced size
  task automatic send_page(input logic [31:0] serial, input bit cont);
    int total = 0;
    send_header(serial, cont, 8'(lacing_tab.size()), -1);
    foreach (lacing_tab[i]) begin
      send_byte(lacing_tab[i]);
      total += lacing_tab[i];
    end
    repeat (total) send_byte(8'($urandom));
  endtask

  // stimulus
  initial begin : stim
    int pick;
    int r;
    int nseg;
    logic [31:0] serial;

    stream_ids[0] = 32'h0000_0000;
    stream_ids[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 8; i++) stream_ids[i] = 32'h0000_0000;
    for (int i = 2; i < 8; i++) stream_ids[i] = unseen_serial();

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // empty pages fill the stream table, extreme serials first
    lacing_tab.delete();
    foreach (stream_ids[i]) send_page(stream_ids[i], 1'b0);
    // unseen serial with the table full
    send_page(unseen_serial(), 1'b0);

    // bad capture byte at each position, then a bad version
    for (int p = 0; p <= HDR_VERSION; p++) send_header(stream_ids[0], 1'b0, 8'd0, p);

    // lacing all zero: lengths but no payload
    lacing_tab = '{8'd0, 8'd0, 8'd0};
    send_page(stream_ids[2], 1'b0);

    // packet spanning pages, interleaved with another stream
    lacing_tab = '{8'd10, 8'd255};
    send_page(stream_ids[3], 1'b0);
    lacing_tab = '{8'd12};
    send_page(stream_ids[4], 1'b0);
    lacing_tab = '{8'd7, 8'd255};
    send_page(stream_ids[3], 1'b1);
    // fresh page drops the open packet
    lacing_tab = '{8'd4};
    send_page(stream_ids[3], 1'b0);
    lacing_tab = '{8'd3};
    send_page(stream_ids[4], 1'b1);

    // largest segment count, small payload
    lacing_tab.delete();
    repeat (255) lacing_tab.push_back(($urandom_range(0, 9) == 0) ? 8'd1 : 8'd0);
    send_page(stream_ids[5], 1'b1);

    // lacing extremes
    lacing_tab = '{8'd0, 8'd254, 8'd1};
    send_page(stream_ids[6], 1'b0);

    // random part: mostly well-formed pages, some broken headers and noise
    while (sent_bytes < TOTAL_ITEMS) begin
      if ($urandom_range(0, 99) < 15) tx_steady = !tx_steady;
      pick = $urandom_range(0, 99);
      if (pick < 82) begin
        lacing_tab.delete();
        r = $urandom_range(0, 99);
        nseg = (r < 10) ? 0 : (r < 85) ? $urandom_range(1, 6) : $urandom_range(7, 24);
        repeat (nseg) begin
          r = $urandom_range(0, 99);
          lacing_tab.push_back((r < 3) ? 8'd255 :
                               (r < 6) ? 8'($urandom_range(21, 254)) :
                                         8'($urandom_range(0, 20)));
        end
        if ($urandom_range(0, 99) < 6) serial = unseen_serial();
        else serial = stream_ids[$urandom_range(0, 7)];
        send_page(serial, 1'($urandom));
      end else if (pick < 92) begin
        send_header(stream_ids[$urandom_range(0, 7)], 1'($urandom), 8'($urandom),
                    $urandom_range(0, HDR_VERSION));
      end else begin
        repeat ($urandom_range(1, 8)) send_byte(8'($urandom));
      end
    end
    in_valid <= 1'b0;

    // let every owed result come out, then a short tail
    do @(posedge clk); while (results_due != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // receiver: random stalls, calm stretches, and one long hold-off
  initial begin : sink
    int cyc = 0;
    int run;
    int stall;
    bit held = 1'b0;
    bit rx_steady = 1'b0;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 99) < 10) rx_steady = !rx_steady;
      run = $urandom_range(1, 24);
      out_ready <= 1'b1;
      repeat (run) @(posedge clk);
      cyc += run;
      if (!held && cyc >= HOLD_AT) begin
        held = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        cyc += HOLD_CYCLES;
      end else begin
        stall = pick_gap(rx_steady);
        if (stall > 0) begin
          out_ready <= 1'b0;
          repeat (stall) @(posedge clk);
          cyc += stall;
        end
      end
    end
  end

  // watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule
